### rtl/core/rcse_pkg.sv
package rcse_pkg;

  // default sizes
  localparam int MAX_SEGMENTS_DEF = 64;
  localparam int MAX_VERTICES_DEF = 128;
  localparam int FRAC_BITS_DEF    = 16;

  // item kinds
  localparam logic [2:0] KIND_BASIS   = 3'd0;
  localparam logic [2:0] KIND_START   = 3'd1;
  localparam logic [2:0] KIND_VERTEX  = 3'd2;
  localparam logic [2:0] KIND_POINT   = 3'd3;
  localparam logic [2:0] KIND_TANGENT = 3'd4;

  // configuration register indexes
  localparam logic CFG_CURVE_ORDER  = 1'b0;
  localparam logic CFG_VERTEX_COUNT = 1'b1;

  localparam logic [2:0] ORDER_RESET = 3'd4;
  localparam logic [7:0] COUNT_RESET = 8'd128;

  // 1.0 in Q1.16
  localparam logic [16:0] T_ONE = 17'd65536;

  typedef struct packed {
    logic [2:0]         kind;
    logic [5:0]         segment_index;
    logic [1:0]         matrix_row;
    logic [1:0]         component;
    logic [6:0]         vertex_slot;
    logic signed [31:0] word_value;
    logic [16:0]        param_t;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               divide_fault;
    logic               range_fault;
  } out_item_t;

  // clamp to 32-bit signed range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

### rtl/core/rcse_store.sv
module rcse_store #(
  parameter int MAX_SEGMENTS = rcse_pkg::MAX_SEGMENTS_DEF,
  parameter int MAX_VERTICES = rcse_pkg::MAX_VERTICES_DEF,
  localparam int SA_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1,
  localparam int VA_W = $clog2(MAX_VERTICES)
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  rcse_pkg::in_item_t    wr_item,
  input  logic [SA_W-1:0]       seg_raddr,
  output logic [6:0]            seg_rdata,
  input  logic [SA_W+3:0]       basis_raddr,
  output logic signed [31:0]    basis_rdata,
  input  logic [VA_W+1:0]       vert_raddr,
  output logic signed [31:0]    vert_rdata
);

  logic signed [31:0] basis_mem [0:MAX_SEGMENTS*16-1];
  logic [6:0]         seg_mem   [0:MAX_SEGMENTS-1];
  logic signed [31:0] vert_mem  [0:MAX_VERTICES*4-1];

  logic [15:0] seg_w;
  logic [15:0] slot_w;
  logic        seg_ok;
  logic        slot_ok;
  logic        basis_we;
  logic        seg_we;
  logic        vert_we;

  // write decode, out-of-range addresses are dropped
  assign seg_w    = {10'd0, wr_item.segment_index};
  assign slot_w   = {9'd0, wr_item.vertex_slot};
  assign seg_ok   = seg_w < 16'(MAX_SEGMENTS);
  assign slot_ok  = slot_w < 16'(MAX_VERTICES);
  assign basis_we = wr_en && seg_ok && (wr_item.kind == rcse_pkg::KIND_BASIS);
  assign seg_we   = wr_en && seg_ok && (wr_item.kind == rcse_pkg::KIND_START);
  assign vert_we  = wr_en && slot_ok && (wr_item.kind == rcse_pkg::KIND_VERTEX);

  always_ff @(posedge clk) begin
    if (basis_we) begin
      basis_mem[{seg_w[SA_W-1:0], wr_item.matrix_row, wr_item.component}] <= wr_item.word_value;
    end
    if (seg_we) begin
      seg_mem[seg_w[SA_W-1:0]] <= wr_item.vertex_slot;
    end
    if (vert_we) begin
      vert_mem[{slot_w[VA_W-1:0], wr_item.component}] <= wr_item.word_value;
    end
  end

  // registered reads
  always_ff @(posedge clk) begin
    seg_rdata   <= seg_mem[seg_raddr];
    basis_rdata <= basis_mem[basis_raddr];
    vert_rdata  <= vert_mem[vert_raddr];
  end

endmodule

### rtl/core/rcse_div.sv
module rcse_div #(
  parameter int FRAC_BITS = rcse_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  logic signed [31:0] num,
  input  logic signed [31:0] den,
  output logic               done,
  output logic signed [31:0] quot
);

  localparam int NW = 32 + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic          run_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [31:0]   rem_r;
  logic [NW-1:0] sh_r;
  logic [31:0]   den_r;
  logic          neg_r;

  logic [31:0] num_mag;
  logic [31:0] den_mag;
  logic [33:0] diff;
  logic        ge;

  assign num_mag = num[31] ? 32'(-num) : num;
  assign den_mag = den[31] ? 32'(-den) : den;

  // restoring step: one quotient bit per cycle, MSB first
  assign diff = {1'b0, rem_r, sh_r[NW-1]} - {2'b00, den_r};
  assign ge   = !diff[33];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(NW - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem_r <= '0;
      sh_r  <= {num_mag, {FRAC_BITS{1'b0}}};
      den_r <= den_mag;
      neg_r <= num[31] ^ den[31];
    end else if (run_r) begin
      rem_r <= ge ? diff[31:0] : {rem_r[30:0], sh_r[NW-1]};
      sh_r  <= {sh_r[NW-2:0], ge};
    end
  end

  // sign and saturate the magnitude
  always_comb begin
    if (neg_r) begin
      quot = (sh_r > NW'(64'h80000000)) ? 32'sh80000000 : 32'(-sh_r[31:0]);
    end else begin
      quot = (sh_r > NW'(64'h7FFFFFFF)) ? 32'sh7FFFFFFF : sh_r[31:0];
    end
  end

  assign done = done_r;

endmodule

### rtl/core/rational_cubic_segment_eval.sv
// Rational cubic segment evaluator.
// Input channel: an item is taken at a rising edge with start high and busy low.
// Kinds basis write, segment start write and vertex write land in the stores at
// that edge, give no result and leave busy low. Point and tangent evaluations
// raise busy until their result has been produced.
// Result channel: out_valid is high for exactly one cycle with out_data; the
// receiver cannot stall, so there is no backpressure path.
// An evaluation steps through S_RANGE, S_T3 and S_MAC, and a point with a nonzero
// weight then through S_DIV; a range fault ends it in S_RANGE, and a tangent or a
// zero-weight point ends it in S_MAC.
// Timing is set by the single shared multiplier, fed from the basis and vertex
// memories one word per cycle (16 + 16 reads, two-deep read/multiply pipe),
// and by three bit-serial dividers running side by side.
// Throughput: one evaluation at a time; writes can be taken every idle cycle.
// Reset clears the sequencer and sets curve_order to 4 and vertex_count to 128;
// the memories are not cleared and must be written before use.
module rational_cubic_segment_eval #(
  parameter int MAX_SEGMENTS = rcse_pkg::MAX_SEGMENTS_DEF,
  parameter int MAX_VERTICES = rcse_pkg::MAX_VERTICES_DEF,
  parameter int FRAC_BITS    = rcse_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  rcse_pkg::in_item_t  in_data,
  output logic                out_valid,
  output rcse_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_wdata
);

  localparam int SA_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int VA_W = $clog2(MAX_VERTICES);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RANGE = 3'd1;
  localparam logic [2:0] S_T3    = 3'd2;
  localparam logic [2:0] S_MAC   = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;

  // config registers
  logic [2:0] curve_order_r;
  logic [7:0] vertex_count_r;

  // sequencer
  logic [2:0]  state_r;
  logic        point_r;
  logic        segok_r;
  logic [SA_W-1:0] seg_r;
  logic [16:0] t_r;
  logic [16:0] t2_r;
  logic [6:0]  start_r;
  logic [17:0] tv_r [0:3];
  logic        ph_r;
  logic [4:0]  cnt_r;
  logic        v1_r;
  logic [3:0]  idx1_r;
  logic        v2_r;
  logic [3:0]  idx2_r;
  logic signed [63:0] prod_r;
  logic signed [63:0] acc_r;
  logic signed [31:0] vv_r [0:3];
  logic signed [31:0] nn_r [0:3];
  logic        div_go_r;
  logic        out_valid_r;
  rcse_pkg::out_item_t out_data_r;

  logic        accept;
  logic [15:0] seg_w;
  logic [6:0]  seg_rdata;
  logic signed [31:0] basis_rdata;
  logic signed [31:0] vert_rdata;
  logic [15:0] vsum;
  logic [2:0]  order_eff;
  logic [12:0] lim;
  logic [12:0] need;
  logic        rfault;
  logic [32:0] t_round;
  logic [16:0] t_nxt;
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] mul_full;
  logic signed [63:0] term;
  logic signed [63:0] sum;
  logic signed [63:0] vsum_rnd;
  logic signed [31:0] grp_sat;
  logic        last_term;
  logic [2:0]  div_done;
  logic signed [31:0] div_q [0:2];

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);
  assign seg_w  = {10'd0, in_data.segment_index};

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      curve_order_r  <= rcse_pkg::ORDER_RESET;
      vertex_count_r <= rcse_pkg::COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rcse_pkg::CFG_CURVE_ORDER:  curve_order_r  <= cfg_wdata[2:0];
        rcse_pkg::CFG_VERTEX_COUNT: vertex_count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stores
  rcse_store #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .MAX_VERTICES (MAX_VERTICES)
  ) u_store (
    .clk         (clk),
    .wr_en       (accept),
    .wr_item     (in_data),
    .seg_raddr   (seg_w[SA_W-1:0]),
    .seg_rdata   (seg_rdata),
    .basis_raddr ({seg_r, cnt_r[1:0], cnt_r[3:2]}),
    .basis_rdata (basis_rdata),
    .vert_raddr  ({vsum[VA_W-1:0], cnt_r[3:2]}),
    .vert_rdata  (vert_rdata)
  );

  // vertex row start + j
  assign vsum = {9'd0, start_r} + {14'd0, cnt_r[1:0]};

  // range check
  assign order_eff = (curve_order_r > 3'd4) ? 3'd4 : curve_order_r;
  assign lim  = ({5'd0, vertex_count_r} > 13'(MAX_VERTICES)) ? 13'(MAX_VERTICES)
                                                             : {5'd0, vertex_count_r};
  assign need = {6'd0, seg_rdata} + {10'd0, order_eff};
  assign rfault = !segok_r || (need > lim);

  // shared multiplier operand select
  always_comb begin
    case (state_r)
      S_RANGE: begin
        mul_a = {16'd0, t_r};
        mul_b = {16'd0, t_r};
      end
      S_T3: begin
        mul_a = {16'd0, t2_r};
        mul_b = {16'd0, t_r};
      end
      default: begin
        if (!ph_r) begin
          mul_a = {15'd0, tv_r[idx1_r[1:0]]};
          mul_b = {basis_rdata[31], basis_rdata};
        end else begin
          mul_a = {vv_r[idx1_r[1:0]][31], vv_r[idx1_r[1:0]]};
          mul_b = {vert_rdata[31], vert_rdata};
        end
      end
    endcase
  end
  assign mul_full = mul_a * mul_b;

  // t powers, rounded half up
  assign t_round = mul_full[32:0] + 33'd32768;
  assign t_nxt   = t_round[32:16];

  // accumulate; vertex terms past the order are masked
  always_comb begin
    if (!ph_r) begin
      term = prod_r;
    end else if ({1'b0, idx2_r[1:0]} < order_eff) begin
      term = (prod_r + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    end else begin
      term = '0;
    end
    sum      = acc_r + term;
    vsum_rnd = (sum + 64'sd32768) >>> 16;
    grp_sat  = rcse_pkg::sat32(ph_r ? sum : vsum_rnd);
    last_term = v2_r && (idx2_r == 4'd15);
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      cnt_r       <= '0;
      ph_r        <= 1'b0;
      div_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      div_go_r    <= 1'b0;
      v2_r        <= v1_r;
      case (state_r)
        S_IDLE: begin
          if (accept && (in_data.kind == rcse_pkg::KIND_POINT ||
                         in_data.kind == rcse_pkg::KIND_TANGENT)) begin
            state_r <= S_RANGE;
          end
        end
        S_RANGE: begin
          if (rfault) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            state_r <= S_T3;
          end
        end
        S_T3: begin
          state_r <= S_MAC;
          cnt_r   <= '0;
          ph_r    <= 1'b0;
        end
        S_MAC: begin
          if (cnt_r < 5'd16) begin
            cnt_r <= cnt_r + 5'd1;
            v1_r  <= 1'b1;
          end else begin
            v1_r <= 1'b0;
          end
          if (last_term) begin
            if (!ph_r) begin
              ph_r  <= 1'b1;
              cnt_r <= '0;
            end else if (!point_r || grp_sat == 32'sd0) begin
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end else begin
              div_go_r <= 1'b1;
              state_r  <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (&div_done) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      point_r <= (in_data.kind == rcse_pkg::KIND_POINT);
      segok_r <= seg_w < 16'(MAX_SEGMENTS);
      seg_r   <= seg_w[SA_W-1:0];
      t_r     <= (in_data.param_t > rcse_pkg::T_ONE) ? rcse_pkg::T_ONE : in_data.param_t;
    end
    if (state_r == S_RANGE) begin
      start_r <= seg_rdata;
      t2_r    <= t_nxt;
    end
    if (state_r == S_T3) begin
      acc_r <= '0;
      if (point_r) begin
        tv_r[0] <= {1'b0, t_nxt};
        tv_r[1] <= {1'b0, t2_r};
        tv_r[2] <= {1'b0, t_r};
        tv_r[3] <= {1'b0, rcse_pkg::T_ONE};
      end else begin
        tv_r[0] <= 18'(3 * t2_r);
        tv_r[1] <= {t_r, 1'b0};
        tv_r[2] <= {1'b0, rcse_pkg::T_ONE};
        tv_r[3] <= '0;
      end
    end
    // tags follow the read data
    idx1_r <= cnt_r[3:0];
    idx2_r <= idx1_r;
    if (v1_r) begin
      prod_r <= mul_full[63:0];
    end
    if (v2_r) begin
      if (idx2_r[1:0] == 2'd3) begin
        acc_r <= '0;
        if (!ph_r) begin
          vv_r[idx2_r[3:2]] <= grp_sat;
        end else begin
          nn_r[idx2_r[3:2]] <= grp_sat;
        end
      end else begin
        acc_r <= sum;
      end
    end
  end

  // three dividers share the weight
  for (genvar c = 0; c < 3; c++) begin : g_div
    rcse_div #(
      .FRAC_BITS (FRAC_BITS)
    ) u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .go    (div_go_r),
      .num   (nn_r[c]),
      .den   (nn_r[3]),
      .done  (div_done[c]),
      .quot  (div_q[c])
    );
  end

  // result register
  always_ff @(posedge clk) begin
    if (state_r == S_RANGE && rfault) begin
      out_data_r <= '{out_x: '0, out_y: '0, out_z: '0, divide_fault: 1'b0, range_fault: 1'b1};
    end else if (state_r == S_MAC && last_term && ph_r) begin
      if (!point_r) begin
        out_data_r <= '{out_x: nn_r[0], out_y: nn_r[1], out_z: nn_r[2],
                        divide_fault: 1'b0, range_fault: 1'b0};
      end else begin
        out_data_r <= '{out_x: '0, out_y: '0, out_z: '0,
                        divide_fault: 1'b1, range_fault: 1'b0};
      end
    end else if (state_r == S_DIV && (&div_done)) begin
      out_data_r <= '{out_x: div_q[0], out_y: div_q[1], out_z: div_q[2],
                      divide_fault: 1'b0, range_fault: 1'b0};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/core/rcse_chk.sv
module rcse_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input rcse_pkg::in_item_t  in_data,
  input logic                out_valid,
  input rcse_pkg::out_item_t out_data
);

  // one evaluation in flight: results never come in adjacent cycles
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result beats back to back");

  // a store write leaves busy low
  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_data.kind == rcse_pkg::KIND_BASIS ||
     in_data.kind == rcse_pkg::KIND_START || in_data.kind == rcse_pkg::KIND_VERTEX))
    |=> !busy) else $error("busy after a write");

  // an evaluation holds the block
  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_data.kind == rcse_pkg::KIND_POINT ||
     in_data.kind == rcse_pkg::KIND_TANGENT)) |=> busy) else $error("eval not started");

  // faults exclude each other and zero the coordinates
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.range_fault || out_data.divide_fault)) |->
    (!(out_data.range_fault && out_data.divide_fault) && out_data.out_x == 32'sd0 &&
     out_data.out_y == 32'sd0 && out_data.out_z == 32'sd0)) else $error("bad fault beat");

endmodule

bind rational_cubic_segment_eval rcse_chk u_rcse_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

### verif/tb.sv
`timescale 1ns / 100ps

module tb;

  // Tracks the block's stores and predicts the result of every evaluation
  class curve_eval_board;
    logic signed [31:0] basis_mem [1024];
    logic [6:0]         seg_first [64];
    logic signed [31:0] vtx_mem   [512];
    bit                 basis_known [64][16];
    bit                 first_known [64];
    int unsigned        order_reg = 4;
    int unsigned        count_reg = 128;
    rcse_pkg::out_item_t pending [$];
    int unsigned        mismatches = 0;

    function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
    endfunction

    // floor((x + half) / 2^16)
    function automatic longint round16(longint x);
      return (x + 64'sd32768) >>> 16;
    endfunction

    function void set_reg(bit idx, logic [7:0] val);
      if (idx == rcse_pkg::CFG_CURVE_ORDER) order_reg = 32'(val & 8'd7);
      else count_reg = 32'(val);
    endfunction

    // Evaluating reads only stores that have been loaded
    function bit can_eval(int seg);
      if (!first_known[seg]) return 0;
      for (int i = 0; i < 16; i++) if (!basis_known[seg][i]) return 0;
      return 1;
    endfunction

    function void note_item(rcse_pkg::in_item_t it);
      longint      tv [4];
      longint      vv [4];
      longint      nv [4];
      longint      acc;
      longint      t;
      longint      t2;
      longint      t3;
      int unsigned ord;
      int unsigned cnt;
      int unsigned first;
      int          seg;
      rcse_pkg::out_item_t exp_item;
      seg = int'(it.segment_index);
      case (it.kind)
        rcse_pkg::KIND_BASIS: begin
          basis_mem[seg * 16 + it.matrix_row * 4 + it.component] = it.word_value;
          basis_known[seg][it.matrix_row * 4 + it.component] = 1;
          return;
        end
        rcse_pkg::KIND_START: begin
          seg_first[seg] = it.vertex_slot;
          first_known[seg] = 1;
          return;
        end
        rcse_pkg::KIND_VERTEX: begin
          vtx_mem[it.vertex_slot * 4 + it.component] = it.word_value;
          return;
        end
        rcse_pkg::KIND_POINT, rcse_pkg::KIND_TANGENT: ;
        default: return;
      endcase
      exp_item = '0;
      ord = (order_reg > 4) ? 4 : order_reg;
      cnt = (count_reg > 128) ? 128 : count_reg;
      first = 32'(seg_first[seg]);
      if (first + ord > cnt) begin
        exp_item.range_fault = 1'b1;
      end else begin
        t = (it.param_t > rcse_pkg::T_ONE) ? 64'sd65536 : longint'(it.param_t);
        t2 = (t * t + 32768) >> 16;
        t3 = (t2 * t + 32768) >> 16;
        if (it.kind == rcse_pkg::KIND_POINT) begin
          tv[0] = t3; tv[1] = t2; tv[2] = t; tv[3] = 65536;
        end else begin
          tv[0] = 3 * t2; tv[1] = 2 * t; tv[2] = 65536; tv[3] = 0;
        end
        // parameter row times basis matrix
        for (int j = 0; j < 4; j++) begin
          acc = 0;
          for (int k = 0; k < 4; k++) acc += tv[k] * longint'(basis_mem[seg * 16 + k * 4 + j]);
          vv[j] = clamp32(round16(acc));
        end
        // weights times geometry rows, unused rows zero
        for (int c = 0; c < 4; c++) begin
          acc = 0;
          for (int j = 0; j < ord; j++)
            acc += round16(vv[j] * longint'(vtx_mem[(first + j) * 4 + c]));
          nv[c] = clamp32(acc);
        end
        if (it.kind == rcse_pkg::KIND_TANGENT) begin
          exp_item.out_x = 32'(nv[0]);
          exp_item.out_y = 32'(nv[1]);
          exp_item.out_z = 32'(nv[2]);
        end else if (nv[3] == 0) begin
          exp_item.divide_fault = 1'b1;
        end else begin
          exp_item.out_x = clamp32((nv[0] * 65536) / nv[3]);
          exp_item.out_y = clamp32((nv[1] * 65536) / nv[3]);
          exp_item.out_z = clamp32((nv[2] * 65536) / nv[3]);
        end
      end
      pending = {pending, exp_item};
    endfunction

    function void check_result(rcse_pkg::out_item_t got);
      rcse_pkg::out_item_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with nothing expected: %p", got);
        return;
      end
      want = pending.pop_front();
      if (got.out_x !== want.out_x || got.out_y !== want.out_y ||
          got.out_z !== want.out_z || got.divide_fault !== want.divide_fault ||
          got.range_fault !== want.range_fault) begin
        mismatches++;
        if (mismatches <= 10) $display("expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  rcse_pkg::in_item_t  in_data;
  logic      out_valid;
  rcse_pkg::out_item_t out_data;
  logic      cfg_we;
  logic      cfg_index;
  logic [7:0] cfg_wdata;

  curve_eval_board board = new();
  int unsigned     sent = 0;

  rational_cubic_segment_eval DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // result beats cannot be held off, take each as it comes
  always @(posedge clk) begin
    if (rst_n && out_valid) board.check_result(out_data);
  end

  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

  // start stays high across back-to-back beats
  task automatic send_item(rcse_pkg::in_item_t it);
    start <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    board.note_item(it);
    sent++;
  endtask

  task automatic pause(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic write_reg(bit idx, logic [7:0] val);
    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    board.set_reg(idx, val);
    cfg_we <= 1'b0;
  endtask

  function automatic rcse_pkg::in_item_t noise_item();
    logic [95:0]        raw;
    rcse_pkg::in_item_t it;
    raw = {$urandom, $urandom, $urandom};
    it = raw[$bits(rcse_pkg::in_item_t)-1:0];
    return it;
  endfunction

  function automatic logic signed [31:0] pick_word(bit weight);
    case ($urandom_range(0, 11))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return 0;
      3, 4: return $urandom;
      default: begin
        if (weight) return $urandom_range(1024, 1 << 17);
        return $signed($urandom_range(0, 1 << 18)) - (1 << 17);
      end
    endcase
  endfunction

  function automatic logic [16:0] pick_t();
    case ($urandom_range(0, 9))
      0: return 17'd0;
      1: return rcse_pkg::T_ONE;
      2: return 17'($urandom_range(65537, 131071));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic write_basis(int seg, int r, int c, logic signed [31:0] w);
    rcse_pkg::in_item_t it;
    it = noise_item();
    it.kind = rcse_pkg::KIND_BASIS;
    it.segment_index = 6'(seg);
    it.matrix_row = 2'(r);
    it.component = 2'(c);
    it.word_value = w;
    send_item(it);
  endtask

  task automatic write_first(int seg, int slot);
    rcse_pkg::in_item_t it;
    it = noise_item();
    it.kind = rcse_pkg::KIND_START;
    it.segment_index = 6'(seg);
    it.vertex_slot = 7'(slot);
    send_item(it);
  endtask

  task automatic write_vertex(int slot, int c, logic signed [31:0] w);
    rcse_pkg::in_item_t it;
    it = noise_item();
    it.kind = rcse_pkg::KIND_VERTEX;
    it.vertex_slot = 7'(slot);
    it.component = 2'(c);
    it.word_value = w;
    send_item(it);
  endtask

  task automatic evaluate(logic [2:0] k, int seg, logic [16:0] t);
    rcse_pkg::in_item_t it;
    it = noise_item();
    it.kind = k;
    it.segment_index = 6'(seg);
    it.param_t = t;
    send_item(it);
  endtask

  task automatic load_segment(int seg, int slot);
    for (int i = 0; i < 16; i++) write_basis(seg, i / 4, i % 4, pick_word(0));
    write_first(seg, slot);
  endtask

  task automatic random_beat(bit quiet);
    int seg;
    int pick;
    rcse_pkg::in_item_t it;
    if (!quiet && $urandom_range(0, 3) == 0) pause($urandom_range(1, 16));
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      load_segment($urandom_range(0, 63), $urandom_range(0, 127));
    end else if (pick < 15) begin
      write_basis($urandom_range(0, 63), $urandom_range(0, 3), $urandom_range(0, 3),
                  pick_word(0));
    end else if (pick < 20) begin
      write_first($urandom_range(0, 63), $urandom_range(0, 127));
    end else if (pick < 32) begin
      seg = $urandom_range(0, 3);
      write_vertex($urandom_range(0, 127), seg, pick_word(seg == 3));
    end else if (pick < 35) begin
      // unknown kinds are dropped by the block and not counted
      it = noise_item();
      it.kind = 3'($urandom_range(5, 7));
      send_item(it);
      sent--;
    end else begin
      seg = 0;
      for (int i = 0; i < 8; i++) begin
        pick = $urandom_range(0, 63);
        if (board.can_eval(pick)) begin
          seg = pick;
          break;
        end
      end
      evaluate(($urandom_range(0, 1) != 0) ? rcse_pkg::KIND_POINT : rcse_pkg::KIND_TANGENT,
               seg, pick_t());
    end
  endtask

  initial begin
    logic [2:0] orders [7] = '{3'd4, 3'd1, 3'd0, 3'd7, 3'd2, 3'd3, 3'd4};
    logic [7:0] counts [7] = '{8'd128, 8'd1, 8'd128, 8'd255, 8'd64, 8'd0, 8'd200};
    int unsigned goal;
    int unsigned phase_len;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = rcse_pkg::CFG_CURVE_ORDER;
    cfg_wdata = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // load every vertex and a few segments so evaluations read known data
    for (int s = 0; s < 128; s++)
      for (int c = 0; c < 4; c++) write_vertex(s, c, pick_word(c == 3));
    for (int s = 0; s < 4; s++) load_segment(s, s * 4);
    write_reg(rcse_pkg::CFG_CURVE_ORDER, {5'b10101, orders[0]});
    write_reg(rcse_pkg::CFG_VERTEX_COUNT, counts[0]);

    // directed: ends of t, clamp of t, zero weight, saturation, bad kinds
    evaluate(rcse_pkg::KIND_POINT, 0, 0);
    evaluate(rcse_pkg::KIND_TANGENT, 0, rcse_pkg::T_ONE);
    evaluate(rcse_pkg::KIND_POINT, 1, 17'h1FFFF);
    for (int c = 0; c < 4; c++) write_basis(2, 3, c, 0);
    for (int s = 8; s < 12; s++) write_vertex(s, 3, 0);
    evaluate(rcse_pkg::KIND_POINT, 2, 0);
    write_first(3, 127);
    evaluate(rcse_pkg::KIND_TANGENT, 3, 100);
    write_vertex(127, 0, 32'sh7FFFFFFF);
    write_basis(1, 0, 0, 32'sh80000000);
    write_basis(1, 1, 1, 32'sh7FFFFFFF);
    evaluate(rcse_pkg::KIND_TANGENT, 1, rcse_pkg::T_ONE);
    for (int k = 5; k < 8; k++) begin
      automatic rcse_pkg::in_item_t it = noise_item();
      it.kind = 3'(k);
      send_item(it);
    end

    // random phases, each under a different register setting
    goal = 1900;
    phase_len = (goal - sent) / 7;
    for (int p = 0; p < 7; p++) begin
      if (p > 0) begin
        write_reg(rcse_pkg::CFG_CURVE_ORDER, {3'($urandom), 2'b00, orders[p]});
        write_reg(rcse_pkg::CFG_VERTEX_COUNT, counts[p]);
      end
      while (sent < goal - (6 - p) * phase_len)
        random_beat(p == 6 && sent > goal - phase_len / 2);
    end
    start <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
